// ===== sv/tkch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkch_pkg
// types, constants and helpers shared by the triangle key hash pipeline
// ----------------------------------------------------------------------------
package tkch_pkg;

  localparam int unsigned WORDS      = 9;
  localparam int unsigned HASH_BASE  = 3;                  // first hash stage
  localparam int unsigned NSTAGE     = HASH_BASE + WORDS;  // total pipeline depth

  typedef logic [31:0]           word_t;
  typedef logic [63:0]           hash_t;
  typedef logic [0:WORDS-1][31:0] seq_t;   // word 0 is most significant
  typedef logic [1:0]            rot_t;

  localparam rot_t ROT_ABC  = 2'd0;
  localparam rot_t ROT_BCA  = 2'd1;
  localparam rot_t ROT_CAB  = 2'd2;
  localparam rot_t ROT_NONE = 2'd3;

  // fnv-1a 64 style constants; the prime is 2^40 + 0x1b3
  // start value is 1469598103934665603, not the standard fnv-1a 64 offset basis
  localparam hash_t      FNV_BASIS    = 64'h1465_0FB0_739D_0383;
  localparam int unsigned FNV_SHIFT   = 40;
  localparam logic [8:0] FNV_PRIME_LO = 9'h1B3;

  // vertex order rotation of a nine-word sequence
  function automatic seq_t rotate(input seq_t s, input rot_t r);
    seq_t o;
    case (r)
      ROT_ABC: o = s;
      ROT_BCA: o = {s[3:8], s[0:2]};
      ROT_CAB: o = {s[6:8], s[0:5]};
      default: o = s;
    endcase
    return o;
  endfunction

  // one fnv-1a step: xor the word in, multiply by the prime mod 2^64
  function automatic hash_t fnv_step(input hash_t h, input word_t w);
    hash_t x;
    x = h ^ {32'd0, w};
    return (x << FNV_SHIFT) + (x * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage

// ===== sv/triangle_key_canonical_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_key_canonical_hash
// picks the smallest vertex rotation of a triangle and hashes it with fnv-1a
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  in_       request in in_valid/in_stall   in_a_x .. in_c_z, 32 bits each
//  out_      result out out_valid/out_stall out_key_hash (64), out_rotation (2)
//
//  one request per cycle while out_stall is low; the stages are an input register,
//  a compare stage, a select stage and one stage per hashed word (nine)
//  each hash stage is one xor plus a multiply by the prime (shift and 9-bit mult)
//  rst_n is synchronous and clears the stage valid bits only
//  stalls ripple back stage by stage: empty stages keep filling, so bubbles
//  close up and a held result never blocks the stages behind an empty slot
//
module triangle_key_canonical_hash (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_a_x,
  input  logic [31:0]          in_a_y,
  input  logic [31:0]          in_a_z,
  input  logic [31:0]          in_b_x,
  input  logic [31:0]          in_b_y,
  input  logic [31:0]          in_b_z,
  input  logic [31:0]          in_c_x,
  input  logic [31:0]          in_c_y,
  input  logic [31:0]          in_c_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_key_hash,
  output logic [1:0]           out_rotation
);

  // per-stage valid bits and advance enables
  logic [tkch_pkg::NSTAGE-1:0] v_r;
  logic [tkch_pkg::NSTAGE-1:0] v_nxt;
  logic [tkch_pkg::NSTAGE-1:0] en;

  // stage 0: captured request, words in abc order
  tkch_pkg::seq_t s0_seq_r;
  // stage 1: original words plus chosen rotation
  tkch_pkg::seq_t s1_seq_r;
  tkch_pkg::rot_t s1_rot_r;
  // stage 2: canonical sequence
  tkch_pkg::seq_t s2_seq_r;
  tkch_pkg::rot_t s2_rot_r;
  // hash stages, one per word
  tkch_pkg::hash_t h_r    [tkch_pkg::WORDS];
  tkch_pkg::seq_t  hq_r   [tkch_pkg::WORDS];
  tkch_pkg::rot_t  hrot_r [tkch_pkg::WORDS];

  // rotation compare
  tkch_pkg::seq_t seq_bca;
  tkch_pkg::seq_t seq_cab;
  logic           lt10;
  logic           lt20;
  logic           lt21;
  tkch_pkg::rot_t rot_pick;

  // ---------------------------------------------------------------------------
  // flow control: a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  assign en[tkch_pkg::NSTAGE-1] = !v_r[tkch_pkg::NSTAGE-1] || !out_stall;

  for (genvar k = 0; k < tkch_pkg::NSTAGE - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign in_stall = !en[0];

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < tkch_pkg::NSTAGE; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: request register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_seq_r <= {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                   in_c_x, in_c_y, in_c_z};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: three parallel 288-bit compares, lexicographic order equals
  // unsigned order with word 0 on top; ties keep the lower rotation
  // ---------------------------------------------------------------------------
  assign seq_bca = tkch_pkg::rotate(s0_seq_r, tkch_pkg::ROT_BCA);
  assign seq_cab = tkch_pkg::rotate(s0_seq_r, tkch_pkg::ROT_CAB);
  assign lt10    = seq_bca < s0_seq_r;
  assign lt20    = seq_cab < s0_seq_r;
  assign lt21    = seq_cab < seq_bca;

  always_comb begin
    if (lt10) begin
      rot_pick = lt21 ? tkch_pkg::ROT_CAB : tkch_pkg::ROT_BCA;
    end else begin
      rot_pick = lt20 ? tkch_pkg::ROT_CAB : tkch_pkg::ROT_ABC;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_seq_r <= s0_seq_r;
      s1_rot_r <= rot_pick;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: rotation mux
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_seq_r <= tkch_pkg::rotate(s1_seq_r, s1_rot_r);
      s2_rot_r <= s1_rot_r;
    end
  end

  // ---------------------------------------------------------------------------
  // hash stages: stage HASH_BASE + j folds word j into the running hash
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < tkch_pkg::WORDS; j++) begin : g_hash
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[tkch_pkg::HASH_BASE]) begin
          h_r[j]    <= tkch_pkg::fnv_step(tkch_pkg::FNV_BASIS, s2_seq_r[j]);
          hq_r[j]   <= s2_seq_r;
          hrot_r[j] <= s2_rot_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[tkch_pkg::HASH_BASE + j]) begin
          h_r[j]    <= tkch_pkg::fnv_step(h_r[j-1], hq_r[j-1][j]);
          hq_r[j]   <= hq_r[j-1];
          hrot_r[j] <= hrot_r[j-1];
        end
      end
    end
  end

  // last hash stage doubles as the output register
  assign out_valid    = v_r[tkch_pkg::NSTAGE-1];
  assign out_key_hash = h_r[tkch_pkg::WORDS-1];
  assign out_rotation = hrot_r[tkch_pkg::WORDS-1];

`ifndef NO_ASSERTIONS
  // reset empties the whole pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  // input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a free stage");

  // the chosen sequence is no larger than any of its rotations
  a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> ((s2_seq_r <= tkch_pkg::rotate(s2_seq_r, tkch_pkg::ROT_BCA)) &&
                (s2_seq_r <= tkch_pkg::rotate(s2_seq_r, tkch_pkg::ROT_CAB))))
    else $error("selected rotation is not the smallest");

  // rotation code three never leaves the block
  a_rot_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rotation != tkch_pkg::ROT_NONE))
    else $error("invalid rotation code on output");
`endif

endmodule
